>>> rtl/itrd_pkg.sv
// Shared constants, register codes and helper functions for the radix digit converter.
package itrd_pkg;

  localparam int ValueW    = 64;
  localparam int MaxDigits = 64;
  localparam int DigitW    = 4;
  localparam int CharW     = 7;
  localparam int RadixW    = 5;
  localparam int WselW     = 2;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 5;
  localparam int CntW      = $clog2(MaxDigits + 1);
  localparam int BitCntW   = $clog2(ValueW);

  localparam logic [CfgIdxW-1:0] RegRadix = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegWsel  = CfgIdxW'(1);

  localparam logic [RadixW-1:0] RadixMin   = RadixW'(2);
  localparam logic [RadixW-1:0] RadixMax   = RadixW'(16);
  localparam logic [RadixW-1:0] RadixDec   = RadixW'(10);
  localparam logic [RadixW-1:0] RadixReset = RadixW'(10);

  localparam logic [WselW-1:0] Wsel4     = WselW'(0);
  localparam logic [WselW-1:0] Wsel8     = WselW'(1);
  localparam logic [WselW-1:0] Wsel16    = WselW'(2);
  localparam logic [WselW-1:0] Wsel32    = WselW'(3);
  localparam logic [WselW-1:0] WselReset = Wsel32;

  localparam logic [CharW-1:0] CharZero  = CharW'(8'h30);
  localparam logic [CharW-1:0] CharA     = CharW'(8'h41);
  localparam logic [CharW-1:0] CharMinus = CharW'(8'h2D);

  // Mask that keeps the low bits of a negative value at the chosen width.
  function automatic logic [ValueW-1:0] width_mask(input logic [WselW-1:0] sel);
    logic [ValueW-1:0] m;
    unique case (sel)
      Wsel4:   m = ValueW'(64'h0000_0000_0000_000F);
      Wsel8:   m = ValueW'(64'h0000_0000_0000_00FF);
      Wsel16:  m = ValueW'(64'h0000_0000_0000_FFFF);
      default: m = ValueW'(64'h0000_0000_FFFF_FFFF);
    endcase
    return m;
  endfunction

  // ASCII code of one digit, '0'-'9' then 'A'-'F'.
  function automatic logic [CharW-1:0] digit_char(input logic [DigitW-1:0] d);
    logic [CharW-1:0] c;
    if (d < DigitW'(10)) begin
      c = CharZero + CharW'(d);
    end else begin
      c = CharA + CharW'(d - DigitW'(10));
    end
    return c;
  endfunction

  // Clamp a written base into 2..16.
  function automatic logic [RadixW-1:0] clamp_radix(input logic [CfgDataW-1:0] v);
    logic [RadixW-1:0] r;
    priority if (RadixW'(v) < RadixMin) begin
      r = RadixMin;
    end else if (RadixW'(v) > RadixMax) begin
      r = RadixMax;
    end else begin
      r = RadixW'(v);
    end
    return r;
  endfunction

endpackage

>>> rtl/integer_to_radix_digits.sv
// Top level: converts a signed integer into ASCII digits of a configured base.
//
//  channel   direction  word contents                          handshake
//  s_axis    in         tdata[63:0] = value                    s_axis_tvalid_i/tready_o
//  m_axis    out        tdata[6:0] = char_code, tdata[7] = 0;  m_axis_tvalid_o/tready_i
//                       tlast = last_char
//  cfg       in         index 0 = radix, 1 = width_select      cfg_valid_i/cfg_ready_o
//
// Steps: a word is accepted, then converted one magnitude bit a cycle shifted into a
// row of 64 radix digit cells; then a minus sign is sent if needed, leading zero
// cells are skipped and the characters are sent one by one.
// Reset clears control state and loads radix 10 and width_select 3 at once.
// A stalled output holds the character register; the sequencer waits on it. A new
// input word is taken as soon as the last character sits in the output register.
module integer_to_radix_digits (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // value[63:0]
  input  logic [itrd_pkg::ValueW-1:0]   s_axis_tdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // char_code[6:0], zero pad[7]
  output logic [7:0]                    m_axis_tdata_o,
  output logic                          m_axis_tlast_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [itrd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [itrd_pkg::CfgDataW-1:0] cfg_data_i
);
  import itrd_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StConv  = 3'd1;
  localparam logic [2:0] StMinus = 3'd2;
  localparam logic [2:0] StSkip  = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;

  // Configuration registers.
  logic [RadixW-1:0] radix_q;
  logic [WselW-1:0]  wsel_q;

  // Sequencer.
  logic [2:0]         state_q, state_d;
  logic [BitCntW-1:0] bit_cnt_q, bit_cnt_d;
  logic [CntW-1:0]    dig_cnt_q, dig_cnt_d;
  logic               minus_q, minus_d;

  // Payload: magnitude shift register and the digit cells.
  logic [ValueW-1:0] mag_q, mag_d;
  logic [DigitW-1:0] cell_q [MaxDigits];
  logic [DigitW-1:0] cell_d [MaxDigits];

  // Output register.
  logic             out_valid_q, out_valid_d;
  logic [CharW-1:0] out_char_q, out_char_d;
  logic             out_last_q, out_last_d;

  logic             s_accept;
  logic             out_free;
  logic             value_neg;
  logic [ValueW-1:0] mag_in;

  // Carry chain of the cells as a generate/propagate add.
  logic [MaxDigits-1:0] gen_v, prop_v;
  logic [MaxDigits:0]   carry_sum;
  logic [MaxDigits:0]   carry_in;
  logic [DigitW-1:0]    cell_next [MaxDigits];

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == StIdle);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_char_q};
  assign m_axis_tlast_o  = out_last_q;

  // Magnitude: negate in base ten, wrap to the chosen width in other bases.
  assign value_neg = s_axis_tdata_i[ValueW-1];
  always_comb begin
    if (value_neg && (radix_q == RadixDec)) begin
      mag_in = ValueW'(0) - s_axis_tdata_i;
    end else if (value_neg) begin
      mag_in = s_axis_tdata_i & width_mask(wsel_q);
    end else begin
      mag_in = s_axis_tdata_i;
    end
  end

  // A cell carries out when 2d + c >= base: always if 2d >= base, and only with
  // a carry in if 2d + 1 == base (odd bases).
  always_comb begin
    for (int k = 0; k < MaxDigits; k++) begin
      gen_v[k]  = ({cell_q[k], 1'b0} >= radix_q);
      prop_v[k] = ({cell_q[k], 1'b1} == radix_q);
    end
    carry_sum = {1'b0, gen_v | prop_v} + {1'b0, gen_v} + (MaxDigits + 1)'(mag_q[ValueW-1]);
    carry_in  = carry_sum ^ {1'b0, prop_v};
    for (int k = 0; k < MaxDigits; k++) begin
      if (carry_in[k+1]) begin
        cell_next[k] = DigitW'({cell_q[k], carry_in[k]} - radix_q);
      end else begin
        cell_next[k] = DigitW'({cell_q[k], carry_in[k]});
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    minus_d     = minus_q;
    mag_d       = mag_q;
    cell_d      = cell_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    // Drop the held word once taken.
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (s_accept) begin
          mag_d     = mag_in;
          minus_d   = value_neg && (radix_q == RadixDec);
          bit_cnt_d = BitCntW'(ValueW - 1);
          for (int k = 0; k < MaxDigits; k++) begin
            cell_d[k] = '0;
          end
          state_d = StConv;
        end
      end
      StConv: begin
        // Shift one magnitude bit into the cells.
        cell_d    = cell_next;
        mag_d     = {mag_q[ValueW-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - BitCntW'(1);
        if (bit_cnt_q == '0) begin
          dig_cnt_d = CntW'(MaxDigits);
          state_d   = minus_q ? StMinus : StSkip;
        end
      end
      StMinus: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CharMinus;
          out_last_d  = 1'b0;
          state_d     = StSkip;
        end
      end
      StSkip: begin
        // Advance past leading zero cells, keeping at least one digit.
        if ((cell_q[MaxDigits-1] == '0) && (dig_cnt_q != CntW'(1))) begin
          for (int k = MaxDigits - 1; k > 0; k--) begin
            cell_d[k] = cell_q[k-1];
          end
          cell_d[0] = '0;
          dig_cnt_d = dig_cnt_q - CntW'(1);
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = digit_char(cell_q[MaxDigits-1]);
          out_last_d  = (dig_cnt_q == CntW'(1));
          for (int k = MaxDigits - 1; k > 0; k--) begin
            cell_d[k] = cell_q[k-1];
          end
          cell_d[0] = '0;
          dig_cnt_d = dig_cnt_q - CntW'(1);
          if (dig_cnt_q == CntW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      minus_q     <= 1'b0;
      out_valid_q <= 1'b0;
      radix_q     <= RadixReset;
      wsel_q      <= WselReset;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      minus_q     <= minus_d;
      out_valid_q <= out_valid_d;
      // Writes beyond the two registers fall through.
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegRadix) begin
          radix_q <= clamp_radix(cfg_data_i);
        end else if (cfg_index_i == RegWsel) begin
          wsel_q <= WselW'(cfg_data_i);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    cell_q     <= cell_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

endmodule

>>> tb/tb_integer_to_radix_digits.sv
// Testbench for the radix digit converter: predicts every character and checks the stream.
`timescale 1ns / 1ps

module tb_integer_to_radix_digits;
  import itrd_pkg::*;

  // Indexes that map to no register; writes there must leave both registers alone.
  localparam logic [CfgIdxW-1:0] RegSpare2 = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegSpare3 = CfgIdxW'(3);

  localparam int RandPhases = 10;
  localparam int ItemsPerPhase = 30;
  localparam int HoldCycles = 500;
  localparam int DrainCycles = 150;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } char_word_t;

  // Predicts the characters of each accepted value and checks the output words in order.
  class digit_predictor;
    logic [RadixW-1:0] radix;
    logic [WselW-1:0]  wsel;
    char_word_t        expected_chars[$];
    int unsigned       mismatches;

    function new();
      radix = RadixW'(10);
      wsel = WselW'(3);
      mismatches = 0;
    endfunction

    function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
      if (idx == RegRadix) begin
        if (data < CfgDataW'(2)) begin
          radix = RadixW'(2);
        end else if (data > CfgDataW'(16)) begin
          radix = RadixW'(16);
        end else begin
          radix = RadixW'(data);
        end
      end else if (idx == RegWsel) begin
        wsel = data[WselW-1:0];
      end
    endfunction

    // Work out the characters that one accepted value must produce.
    function void note_value(input logic [ValueW-1:0] v);
      logic [ValueW-1:0] mag;
      logic [ValueW-1:0] base;
      logic [DigitW-1:0] cells[MaxDigits];
      int                n;
      char_word_t        w;
      base = ValueW'(radix);
      if (v[ValueW-1] && radix == RadixDec) begin
        w.code = CharMinus;
        w.last = 1'b0;
        expected_chars.push_back(w);
        mag = -v;
      end else if (v[ValueW-1]) begin
        // two's complement at the selected width, i.e. the value modulo 2^(4 << wsel)
        mag = v & ((ValueW'(1) << (4 << wsel)) - ValueW'(1));
      end else begin
        mag = v;
      end
      n = 0;
      do begin
        cells[n] = DigitW'(mag % base);
        mag = mag / base;
        n++;
      end while (mag != 0);
      for (int i = n - 1; i >= 0; i--) begin
        w.code = (cells[i] < DigitW'(10)) ? CharZero + CharW'(cells[i])
                                          : CharA + CharW'(cells[i] - DigitW'(10));
        w.last = (i == 0);
        expected_chars.push_back(w);
      end
    endfunction

    function void check_char(input logic [CharW-1:0] code, input logic last);
      char_word_t w;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: char %02h last %0d with nothing expected", code, last);
        end
      end else begin
        w = expected_chars.pop_front();
        if (w.code !== code || w.last !== last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected char %02h last %0d, got char %02h last %0d",
                     w.code, w.last, code, last);
          end
        end
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic [ValueW-1:0]   s_axis_tdata_i;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [7:0]          m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  digit_predictor digits;
  logic           hold_req;
  int unsigned    burst_left;

  integer_to_radix_digits i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // Check every output word taken at a rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      digits.check_char(m_axis_tdata_o[CharW-1:0], m_axis_tlast_o);
    end
  end

  // Receiver: stall on its own changing pattern; honor one long hold-off on request.
  initial begin
    int unsigned cyc;
    int unsigned mode;
    logic        held;
    cyc = 0;
    mode = 0;
    held = 1'b0;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        m_axis_tready_i = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      if (cyc % 64 == 0) begin
        mode = $urandom_range(0, 3);
      end
      case (mode)
        0: m_axis_tready_i = 1'b1;
        1: m_axis_tready_i = ($urandom_range(0, 1) != 0);
        2: m_axis_tready_i = ($urandom_range(0, 7) != 0);
        default: m_axis_tready_i = (cyc % 5 != 0);
      endcase
      cyc++;
    end
  end

  // Offer one word; a nonzero gap idles the input first.
  task automatic send_value(input logic [ValueW-1:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
    end else begin
      gap = 0;
    end
    burst_left--;
    if (gap != 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i = v;
    s_axis_tvalid_i = 1'b1;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready_o);
    digits.note_value(v);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    digits.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Drop the input valid and wait until every predicted character has come out.
  task automatic wait_idle();
    s_axis_tvalid_i = 1'b0;
    while (digits.pending() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  function automatic logic [ValueW-1:0] random_value();
    logic [ValueW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = {$urandom, $urandom};
      4: v = ValueW'($urandom_range(0, 300));
      5: v = -ValueW'($urandom_range(1, 300));
      6: begin
        v = {$urandom, $urandom} >> $urandom_range(0, 63);
        if ($urandom_range(0, 1) != 0) begin
          v = -v;
        end
      end
      // negative multiples of a power of two: these wrap to zero at small widths
      7: v = -(ValueW'($urandom_range(1, 15)) << $urandom_range(4, 40));
      8: begin
        case ($urandom_range(0, 4))
          0: v = '0;
          1: v = {1'b0, {(ValueW-1){1'b1}}};
          2: v = {1'b1, {(ValueW-1){1'b0}}};
          3: v = '1;
          default: v = ValueW'(1);
        endcase
      end
      default: begin
        v = ValueW'(1) << $urandom_range(0, 62);
        v = v + ValueW'($urandom_range(0, 2)) - ValueW'(1);
      end
    endcase
    return v;
  endfunction

  initial begin
    digits = new();
    hold_req = 1'b0;
    burst_left = 0;
    rst_ni = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tvalid_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegRadix;
    cfg_data_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: base 10, minus sign path, zero and both extremes.
    send_value('0);
    send_value(ValueW'(1));
    send_value('1);
    send_value({1'b0, {(ValueW-1){1'b1}}});
    send_value({1'b1, {(ValueW-1){1'b0}}});
    send_value(-ValueW'(10));
    send_value(ValueW'(1234567890));
    send_value(ValueW'(9));
    send_value(ValueW'(10));
    wait_idle();

    // Base 16 at 4-bit width; the spare index write must change nothing.
    write_reg(RegRadix, CfgDataW'(16));
    write_reg(RegWsel, CfgDataW'(0));
    write_reg(RegSpare2, CfgDataW'(3));
    send_value(-ValueW'(16));
    send_value('1);
    send_value({1'b1, {(ValueW-1){1'b0}}});
    send_value({1'b0, {(ValueW-1){1'b1}}});
    send_value(64'hFEDC_BA98_7654_3210);
    send_value(ValueW'(255));
    wait_idle();

    // Base written below range saturates to 2; width keeps its low bits only.
    write_reg(RegRadix, CfgDataW'(0));
    write_reg(RegWsel, CfgDataW'(31));
    write_reg(RegSpare3, CfgDataW'(31));
    send_value({1'b0, {(ValueW-1){1'b1}}});
    send_value('1);
    send_value({1'b1, {(ValueW-1){1'b0}}});
    send_value(ValueW'(1));
    wait_idle();

    for (int p = 0; p < RandPhases; p++) begin
      case (p)
        0: begin
          write_reg(RegRadix, CfgDataW'(31));
          write_reg(RegWsel, CfgDataW'(4));
        end
        1: begin
          write_reg(RegRadix, CfgDataW'(1));
          write_reg(RegWsel, CfgDataW'(2));
        end
        2: begin
          write_reg(RegRadix, CfgDataW'(10));
          write_reg(RegWsel, CfgDataW'(1));
        end
        default: begin
          write_reg(RegRadix, CfgDataW'($urandom_range(0, 31)));
          write_reg(RegWsel, CfgDataW'($urandom_range(0, 31)));
          if ($urandom_range(0, 2) == 0) begin
            write_reg($urandom_range(0, 1) ? RegSpare2 : RegSpare3,
                      CfgDataW'($urandom_range(0, 31)));
          end
        end
      endcase
      for (int k = 0; k < ItemsPerPhase; k++) begin
        // Hold the output off for a long stretch while words keep coming in.
        if (p == 3 && k == 4) begin
          hold_req = 1'b1;
        end
        send_value(random_value());
      end
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (digits.mismatches == 0 && digits.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/itrd_pkg.sv
rtl/integer_to_radix_digits.sv
tb/tb_integer_to_radix_digits.sv
